// ----- rtl/utf16_to_utf8_encoder_macros.svh -----
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder assertion macros
// Shared concurrent assertion forms; they compile to nothing when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_ENCODER_MACROS_SVH
`define UTF16_TO_UTF8_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// The condition holds at every clock edge outside reset.
`define U2U8_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("u2u8: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define U2U8_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u2u8: implication violated");

// The consequent holds in the cycle after the antecedent.
`define U2U8_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u2u8: next-cycle implication violated");

`else

`define U2U8_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define U2U8_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define U2U8_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/u2u8_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder package
// Shared constants, job types and byte encoding functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u2u8_pkg;

    // Most bytes one request can produce: flushed surrogate, unit, terminator.
    localparam int JOB_BYTES = 7;
    localparam int JOB_IDX_W = $clog2(JOB_BYTES);

    // Job queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [15:0] MASK_ONE_BYTE  = 16'hFF80;
    localparam logic [15:0] MASK_TWO_BYTE  = 16'hF800;
    localparam logic [15:0] MASK_SURROGATE = 16'hFC00;
    localparam logic [15:0] HIGH_SURR_TAG  = 16'hD800;
    localparam logic [15:0] LOW_SURR_TAG   = 16'hDC00;
    localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;

    localparam logic [7:0] LEAD_FOUR  = 8'hF0;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] LEAD_TWO   = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;

    typedef logic [7:0] byte_t;

    // A run of up to four encoded bytes, first byte at index 0.
    typedef struct packed {
        byte_t [3:0]          bytes;
        logic  [JOB_IDX_W-1:0] count;
    } seg_t;

    // Everything the back end needs to emit one request's bytes.
    typedef struct packed {
        byte_t [JOB_BYTES-1:0] bytes;
        logic  [JOB_IDX_W-1:0] count;
        logic                  has_term;
    } job_t;

    function automatic seg_t enc_single(logic [15:0] u);
        seg_t s;
        s = '0;
        if ((u & MASK_ONE_BYTE) == 16'h0000)
        begin
            s.bytes[0] = u[7:0];
            s.count    = JOB_IDX_W'(1);
        end
        else if ((u & MASK_TWO_BYTE) == 16'h0000)
        begin
            s.bytes[0] = LEAD_TWO | {3'b000, u[10:6]};
            s.bytes[1] = CONT_TAG | {2'b00, u[5:0]};
            s.count    = JOB_IDX_W'(2);
        end
        else
        begin
            s.bytes[0] = LEAD_THREE | {4'b0000, u[15:12]};
            s.bytes[1] = CONT_TAG | {2'b00, u[11:6]};
            s.bytes[2] = CONT_TAG | {2'b00, u[5:0]};
            s.count    = JOB_IDX_W'(3);
        end
        return s;
    endfunction

    function automatic seg_t enc_pair(logic [15:0] hi, logic [15:0] lo);
        seg_t        s;
        logic [20:0] cp;
        cp = SUPPLEMENTARY_BASE + {1'b0, hi[9:0], lo[9:0]};
        s.bytes[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
        s.bytes[1] = CONT_TAG | {2'b00, cp[17:12]};
        s.bytes[2] = CONT_TAG | {2'b00, cp[11:6]};
        s.bytes[3] = CONT_TAG | {2'b00, cp[5:0]};
        s.count    = JOB_IDX_W'(4);
        return s;
    endfunction

endpackage

// ----- rtl/u2u8_queue.sv -----
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 job queue
// Short first-in first-out store of encoded jobs between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf16_to_utf8_encoder_macros.svh"

module u2u8_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  u2u8_pkg::job_t  wdata,
    output logic            full,
    input  logic            pop,
    output u2u8_pkg::job_t  rdata,
    output logic            empty
);

    u2u8_pkg::job_t                   mem_reg [u2u8_pkg::QDEPTH];
    logic [u2u8_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [u2u8_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [u2u8_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                             do_push, do_pop;

    localparam logic [u2u8_pkg::QPTR_W-1:0] PTR_LAST = u2u8_pkg::QPTR_W'(u2u8_pkg::QDEPTH - 1);
    localparam logic [u2u8_pkg::QCNT_W-1:0] CNT_FULL = u2u8_pkg::QCNT_W'(u2u8_pkg::QDEPTH);

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `U2U8_ASSERT_ALWAYS(a_count_in_range, clk, rst_n, count_reg <= CNT_FULL)
    `U2U8_ASSERT_NEXT(a_push_only_grows, clk, rst_n, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ----- rtl/u2u8_front.sv -----
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 front end
// Accepts code units, tracks surrogate and string state, builds byte jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u2u8_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [15:0]     code_unit,
    input  logic            final_unit,
    input  logic            q_full,
    output logic            q_push,
    output u2u8_pkg::job_t  q_wdata
);

    logic [15:0]       held_high_reg, held_high_next;
    logic              held_valid_reg, held_valid_next;
    logic              string_ended_reg, string_ended_next;
    logic              accept;
    logic              is_low, is_high;
    logic              term;
    u2u8_pkg::seg_t    seg_a, seg_b;
    u2u8_pkg::job_t    job;

    assign accept  = push && !q_full;
    assign is_low  = ((code_unit & u2u8_pkg::MASK_SURROGATE) == u2u8_pkg::LOW_SURR_TAG);
    assign is_high = ((code_unit & u2u8_pkg::MASK_SURROGATE) == u2u8_pkg::HIGH_SURR_TAG);

    // Classification: segment A is a flushed or paired surrogate, segment B the unit itself.
    always_comb
    begin
        held_high_next    = held_high_reg;
        held_valid_next   = held_valid_reg;
        string_ended_next = string_ended_reg;
        seg_a             = '0;
        seg_b             = '0;
        term              = 1'b0;
        if (string_ended_reg)
        begin
            if (final_unit)
            begin
                string_ended_next = 1'b0;
            end
        end
        else if (held_valid_reg && is_low)
        begin
            held_valid_next = 1'b0;
            held_high_next  = '0;
            seg_a           = u2u8_pkg::enc_pair(held_high_reg, code_unit);
            term            = final_unit;
        end
        else
        begin
            if (held_valid_reg)
            begin
                held_valid_next = 1'b0;
                held_high_next  = '0;
                seg_a           = u2u8_pkg::enc_single(held_high_reg);
            end
            if (code_unit == 16'h0000)
            begin
                term              = 1'b1;
                string_ended_next = !final_unit;
            end
            else if (is_high && !final_unit)
            begin
                held_high_next  = code_unit;
                held_valid_next = 1'b1;
            end
            else
            begin
                seg_b = u2u8_pkg::enc_single(code_unit);
                term  = final_unit;
            end
        end
    end

    // Pack both segments back to back; the terminator slot is already zero.
    always_comb
    begin
        job = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (u2u8_pkg::JOB_IDX_W'(k) < seg_a.count)
            begin
                job.bytes[u2u8_pkg::JOB_IDX_W'(k)] = seg_a.bytes[2'(k)];
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            if (u2u8_pkg::JOB_IDX_W'(k) < seg_b.count)
            begin
                job.bytes[seg_a.count + u2u8_pkg::JOB_IDX_W'(k)] = seg_b.bytes[2'(k)];
            end
        end
        job.count    = seg_a.count + seg_b.count + u2u8_pkg::JOB_IDX_W'(term);
        job.has_term = term;
    end

    assign q_push  = accept && (job.count != '0);
    assign q_wdata = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_high_reg    <= '0;
            held_valid_reg   <= 1'b0;
            string_ended_reg <= 1'b0;
        end
        else if (accept)
        begin
            held_high_reg    <= held_high_next;
            held_valid_reg   <= held_valid_next;
            string_ended_reg <= string_ended_next;
        end
    end

endmodule

// ----- rtl/u2u8_back.sv -----
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 back end
// Walks the head job into a registered result stage, one byte per cycle while the result side pops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf16_to_utf8_encoder_macros.svh"

module u2u8_back (
    input  logic            clk,
    input  logic            rst_n,
    input  u2u8_pkg::job_t  head,
    input  logic            head_valid,
    output logic            head_pop,
    input  logic            pop,
    output logic            empty,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            is_terminator
);

    logic [u2u8_pkg::JOB_IDX_W-1:0] idx_reg, idx_next;
    logic                           out_valid_reg, out_valid_next;
    logic [7:0]                     out_byte_reg;
    logic                           run_last_reg;
    logic                           term_reg;
    logic                           load;
    logic                           last;

    assign load = head_valid && (!out_valid_reg || pop);
    assign last = (idx_reg == head.count - 1'b1);

    always_comb
    begin
        idx_next       = idx_reg;
        head_pop       = 1'b0;
        out_valid_next = out_valid_reg && !pop;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (last)
            begin
                idx_next = '0;
                head_pop = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= head.bytes[idx_reg];
            run_last_reg <= last;
            term_reg     <= last && head.has_term;
        end
    end

    assign empty         = !out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign run_last      = run_last_reg;
    assign is_terminator = term_reg;

    `U2U8_ASSERT_IMPLIES(a_head_not_blank, clk, rst_n, head_valid, head.count != '0)
    `U2U8_ASSERT_IMPLIES(a_term_is_last_zero, clk, rst_n, out_valid_reg && term_reg, run_last_reg && (out_byte_reg == 8'h00))

endmodule

// ----- rtl/utf16_to_utf8_encoder.sv -----
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder
// Streams UTF-16 code units in and UTF-8 bytes out, pairing surrogates and
// terminating strings.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   ------------------------------------------
//  input     push / full          code_unit[15:0], final_unit
//  result    pop / empty          out_byte[7:0], run_last, is_terminator
//
// A request is taken in every cycle while the two-entry job queue has room;
// the back end then emits one byte per cycle while the result side pops,
// 0 to 7 bytes per request (one to three for ordinary text). The
// single-byte result register sets that rate. With the back end idle, the
// first byte of a request passes the job queue, then the result register.
// Reset clears the surrogate and string state, the queue and the result
// register at once; there is no clearing pass.
// A stalled result side fills the queue and then raises full; the front end
// keeps its state until the next request is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf16_to_utf8_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] code_unit,
    input  logic        final_unit,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        run_last,
    output logic        is_terminator
);

    // Jobs hold every byte of one request; requests that produce nothing
    // (a held high surrogate, units after a terminator) never reach the queue.
    u2u8_pkg::job_t q_wdata;
    u2u8_pkg::job_t q_rdata;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;

    // Front end: classification and surrogate state, one request per cycle while the queue has room.
    u2u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .code_unit  (code_unit),
        .final_unit (final_unit),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    // The queue lets the front end keep taking requests while bytes drain.
    u2u8_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // Back end: byte serialiser with its own result register.
    u2u8_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_rdata),
        .head_valid    (!q_empty),
        .head_pop      (q_pop),
        .pop           (pop),
        .empty         (empty),
        .out_byte      (out_byte),
        .run_last      (run_last),
        .is_terminator (is_terminator)
    );

    assign full = q_full;

endmodule

// ----- dv/tb_utf16_to_utf8_encoder.sv -----
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder testbench
// Feeds code units through the push/full side and checks every byte taken
// from the pop/empty side against typed bytes or a transaction-level model of the encoder.
// A short table of hand-picked units comes first, then random text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_utf16_to_utf8_encoder;

    // Random requests to send, not counting units swallowed after a string end;
    // with those and the directed table the run sends close to 270 requests.
    localparam int RANDOM_UNITS = 220;
    // Cycles without any transfer on either side before the run is abandoned.
    // The longest correct quiet spell is the forced receiver hold-off below.
    localparam int WATCHDOG_LIMIT = 2000;
    // Length of the one long receiver stall that is meant to fill the block.
    localparam int LONG_HOLD = 150;
    // Cycles to wait after the last expected byte for anything stray.
    localparam int DRAIN_CYCLES = 12;

    // One expected output byte with its two flags.
    typedef struct packed {
        logic [7:0] value;
        logic       run_end;
        logic       term_flag;
    } utf8_byte_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [15:0] code_unit;
    logic        final_unit;
    logic        empty;
    logic        pop;
    logic [7:0]  out_byte;
    logic        run_last;
    logic        is_terminator;

    // Model state: a held high surrogate and the string-closed flag.
    logic [15:0] pending_high;
    logic        pending_ok;
    logic        string_closed;

    // Bytes produced by the request being modelled, and all bytes still due.
    utf8_byte_t  unit_bytes[$];
    utf8_byte_t  utf8_due[$];

    // Directed table: unit, final flag, byte count (-1 means use the model)
    // and the expected bytes packed from the top, first byte leftmost.
    logic [15:0] row_unit[$];
    logic        row_final[$];
    int          row_count[$];
    logic [55:0] row_bytes[$];

    int          error_count;
    int          idle_cycles;
    bit          hold_off_req;

    utf16_to_utf8_encoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .code_unit     (code_unit),
        .final_unit    (final_unit),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .run_last      (run_last),
        .is_terminator (is_terminator)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Every input has a defined level from time zero.
    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        code_unit     = 16'h0000;
        final_unit    = 1'b0;
        pop           = 1'b0;
        pending_high  = 16'h0000;
        pending_ok    = 1'b0;
        string_closed = 1'b0;
        error_count   = 0;
        idle_cycles   = 0;
        hold_off_req  = 1'b0;
    end

    // Idle lengths: mostly from the shortest range, sometimes the middle one, now and then a long pause.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 93)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(15, 40);
    endfunction

    // Adds one byte to the bytes of the request being modelled.
    task automatic append_byte(input logic [7:0] value, input logic term);
        utf8_byte_t b;
        b.value     = value;
        b.run_end   = 1'b0;
        b.term_flag = term;
        unit_bytes.insert(unit_bytes.size(), b);
    endtask

    // Appends the one, two or three byte form of a single code unit. Lone
    // surrogates take the three byte form like any other unit above 0x7FF.
    task automatic encode_single(input logic [15:0] u);
        if (u[15:7] == 9'd0)
        begin
            append_byte(u[7:0], 1'b0);
        end
        else if (u[15:11] == 5'd0)
        begin
            append_byte({3'b110, u[10:6]}, 1'b0);
            append_byte({2'b10, u[5:0]}, 1'b0);
        end
        else
        begin
            append_byte({4'b1110, u[15:12]}, 1'b0);
            append_byte({2'b10, u[11:6]}, 1'b0);
            append_byte({2'b10, u[5:0]}, 1'b0);
        end
    endtask

    // Works out the bytes one accepted request produces and advances the
    // model state. The result is left in unit_bytes with the run end marked.
    task automatic transcode_unit(input logic [15:0] u, input logic fin);
        logic [20:0] cp;
        logic        paired;
        paired = 1'b0;
        unit_bytes.delete();
        if (string_closed)
        begin
            // Everything up to the final unit is swallowed without output.
            if (fin)
            begin
                string_closed = 1'b0;
            end
        end
        else
        begin
            if (pending_ok)
            begin
                pending_ok = 1'b0;
                if (u[15:10] == 6'b110111)
                begin
                    // A proper pair: four bytes for the supplementary code point.
                    cp = 21'h10000 + {1'b0, pending_high[9:0], u[9:0]};
                    append_byte({5'b11110, cp[20:18]}, 1'b0);
                    append_byte({2'b10, cp[17:12]}, 1'b0);
                    append_byte({2'b10, cp[11:6]}, 1'b0);
                    append_byte({2'b10, cp[5:0]}, 1'b0);
                    if (fin)
                    begin
                        append_byte(8'h00, 1'b1);
                    end
                    paired = 1'b1;
                end
                else
                begin
                    // The held high surrogate had no partner, so it goes out alone.
                    encode_single(pending_high);
                end
                pending_high = 16'h0000;
            end
            if (!paired)
            begin
                if (u == 16'h0000)
                begin
                    append_byte(8'h00, 1'b1);
                    string_closed = !fin;
                end
                else if (u[15:10] == 6'b110110 && !fin)
                begin
                    pending_high = u;
                    pending_ok   = 1'b1;
                end
                else
                begin
                    encode_single(u);
                    if (fin)
                    begin
                        append_byte(8'h00, 1'b1);
                    end
                end
            end
        end
        if (unit_bytes.size() > 0)
        begin
            unit_bytes[unit_bytes.size() - 1].run_end = 1'b1;
        end
    endtask

    // Offers one request, waits for it to be taken and records what it owes.
    // A count of -1 takes the model's bytes; otherwise the typed bytes are due.
    task automatic offer_unit(input logic [15:0] u, input logic fin, input bit calm,
                              input int count, input logic [55:0] bytes);
        int         gap;
        utf8_byte_t b;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 35)
        begin
            gap = idle_len();
        end
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push       <= 1'b1;
        code_unit  <= u;
        final_unit <= fin;
        // full is sampled as it stood just before the edge.
        do
        begin
            @(posedge clk);
        end
        while (full);
        transcode_unit(u, fin);
        if (count < 0)
        begin
            foreach (unit_bytes[k])
            begin
                utf8_due.insert(utf8_due.size(), unit_bytes[k]);
            end
        end
        else
        begin
            for (int k = 0; k < count; k++)
            begin
                b.value     = bytes[55 - 8 * k -: 8];
                b.run_end   = (k == count - 1);
                b.term_flag = (b.value == 8'h00);
                utf8_due.insert(utf8_due.size(), b);
            end
        end
    endtask

    task automatic add_row(input logic [15:0] u, input logic fin, input int count,
                           input logic [55:0] bytes);
        row_unit.insert(row_unit.size(), u);
        row_final.insert(row_final.size(), fin);
        row_count.insert(row_count.size(), count);
        row_bytes.insert(row_bytes.size(), bytes);
    endtask

    // Request side: reset, the directed table, then random text.
    initial
    begin
        int          counted;
        int          r;
        bit          low_next;
        bit          calm;
        logic [15:0] u;
        logic        fin;
        counted  = 0;
        low_next = 1'b0;

        // Boundaries of the one, two and three byte forms.
        add_row(16'h0041, 1'b0, 1, 56'h41_00_00_00_00_00_00);
        add_row(16'h007F, 1'b0, 1, 56'h7F_00_00_00_00_00_00);
        add_row(16'h0080, 1'b0, 2, 56'hC2_80_00_00_00_00_00);
        add_row(16'h07FF, 1'b0, 2, 56'hDF_BF_00_00_00_00_00);
        add_row(16'h0800, 1'b0, 3, 56'hE0_A0_80_00_00_00_00);
        add_row(16'hFFFF, 1'b0, 3, 56'hEF_BF_BF_00_00_00_00);
        // Lowest and highest surrogate pairs; the high half alone gives nothing.
        add_row(16'hD800, 1'b0, 0, 56'h0);
        add_row(16'hDC00, 1'b0, 4, 56'hF0_90_80_80_00_00_00);
        add_row(16'hDBFF, 1'b0, 0, 56'h0);
        add_row(16'hDFFF, 1'b0, 4, 56'hF4_8F_BF_BF_00_00_00);
        // A low surrogate on its own.
        add_row(16'hDC00, 1'b0, 3, 56'hED_B0_80_00_00_00_00);
        // A high surrogate followed by ordinary text is flushed first.
        add_row(16'hD800, 1'b0, 0, 56'h0);
        add_row(16'h0041, 1'b0, 4, 56'hED_A0_80_41_00_00_00);
        // A zero unit flushes the held surrogate, then terminates the string.
        add_row(16'hD83D, 1'b0, 0, 56'h0);
        add_row(16'h0000, 1'b0, 4, 56'hED_A0_BD_00_00_00_00);
        // After the end of a string everything is ignored up to the final unit.
        add_row(16'h1234, 1'b0, 0, 56'h0);
        add_row(16'hD800, 1'b0, 0, 56'h0);
        add_row(16'h0041, 1'b1, 0, 56'h0);
        // A high surrogate as the final unit goes out alone, then the terminator.
        add_row(16'hD801, 1'b1, 4, 56'hED_A0_81_00_00_00_00);
        // A pair completed by the final unit, followed by the terminator.
        add_row(16'hD83D, 1'b0, 0, 56'h0);
        add_row(16'hDE00, 1'b1, 5, 56'hF0_9F_98_80_00_00_00);
        // A zero unit that is also final leaves the next string open.
        add_row(16'h0000, 1'b1, 1, 56'h00_00_00_00_00_00_00);
        add_row(16'h00E9, 1'b1, 3, 56'hC3_A9_00_00_00_00_00);
        // Worst case length: a flushed surrogate, a three byte unit and the end.
        add_row(16'hDBFF, 1'b0, -1, 56'h0);
        add_row(16'hE000, 1'b1, -1, 56'h0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (row_unit[i])
        begin
            offer_unit(row_unit[i], row_final[i], 1'b0, row_count[i], row_bytes[i]);
        end

        // Random text, mostly well formed: ordinary units and complete pairs,
        // with broken pairs, stray surrogates, zero units and arbitrary values
        // mixed in. The receiver is asked to stall for a long while at the
        // start, and the sender keeps pushing so that full must rise.
        hold_off_req = 1'b1;
        for (int idx = 0; counted < RANDOM_UNITS; idx++)
        begin
            calm = (idx < 30) || ((idx / 50) % 3 == 1);
            if (low_next)
            begin
                u        = 16'hDC00 | 16'($urandom_range(0, 1023));
                low_next = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 30)
                begin
                    u = 16'($urandom_range(1, 127));
                end
                else if (r < 45)
                begin
                    u = 16'($urandom_range(128, 2047));
                end
                else if (r < 60)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        u = 16'($urandom_range(16'h0800, 16'hD7FF));
                    end
                    else
                    begin
                        u = 16'($urandom_range(16'hE000, 16'hFFFF));
                    end
                end
                else if (r < 80)
                begin
                    u        = 16'hD800 | 16'($urandom_range(0, 1023));
                    low_next = 1'b1;
                end
                else if (r < 85)
                begin
                    u = 16'hD800 | 16'($urandom_range(0, 1023));
                end
                else if (r < 89)
                begin
                    u = 16'hDC00 | 16'($urandom_range(0, 1023));
                end
                else if (r < 92)
                begin
                    u = 16'h0000;
                end
                else
                begin
                    u = 16'($urandom_range(0, 65535));
                end
            end
            // Once a string has ended, bring the final unit round sooner.
            if (string_closed)
            begin
                fin = ($urandom_range(0, 99) < 30);
            end
            else
            begin
                fin = ($urandom_range(0, 99) < 4);
                counted++;
            end
            offer_unit(u, fin, calm, -1, 56'h0);
        end
        push <= 1'b0;

        while (utf8_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("[utf16_to_utf8_encoder] OK");
        end
        else
        begin
            $display("[utf16_to_utf8_encoder] ERROR");
        end
        $finish;
    end

    // Result side: take bytes, compare them with the oldest one due, and
    // throttle pop with random stalls, calm stretches and one long hold-off.
    initial
    begin
        int         rx_hold;
        int         rx_cycle;
        utf8_byte_t due;
        rx_hold  = 0;
        rx_cycle = 0;
        while (rst_n !== 1'b1)
        begin
            @(posedge clk);
        end
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (utf8_due.size() == 0)
                begin
                    $error("unexpected byte %h with no request outstanding", out_byte);
                    error_count++;
                end
                else
                begin
                    due = utf8_due.pop_front();
                    if (out_byte !== due.value)
                    begin
                        $error("out_byte: expected %h, got %h", due.value, out_byte);
                        error_count++;
                    end
                    if (run_last !== due.run_end)
                    begin
                        $error("run_last: expected %b, got %b", due.run_end, run_last);
                        error_count++;
                    end
                    if (is_terminator !== due.term_flag)
                    begin
                        $error("is_terminator: expected %b, got %b",
                               due.term_flag, is_terminator);
                        error_count++;
                    end
                end
            end
            rx_cycle++;
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rx_hold      = LONG_HOLD;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                pop <= 1'b0;
            end
            else if (((rx_cycle / 200) % 3 != 1) && $urandom_range(0, 99) < 25)
            begin
                // The stall covers this cycle and the ones counted off after it.
                rx_hold = idle_len() - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: any cycle that moves a request or a byte resets the count.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[utf16_to_utf8_encoder] ERROR");
            $finish;
        end
    end

endmodule
